[rtl/core/fixed_point_to_radix_text_unit_macros.svh]
// Assertion macros shared by the radix text unit RTL.
// Depends on nothing; each user must have clk and arst_n in scope.
`ifndef FIXED_POINT_TO_RADIX_TEXT_UNIT_MACROS_SVH
`define FIXED_POINT_TO_RADIX_TEXT_UNIT_MACROS_SVH

// Same-cycle implication.
`define FPRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FPRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/fprt_pkg.sv]
// Types, constants and character helper for the radix text unit.
// No dependencies.
package fprt_pkg;

	localparam int DIG_W         = 4;
	localparam int CHAR_W        = 7;
	localparam int RADIX_W       = 5;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 5;
	localparam int BITS_PER_STEP = 4;
	localparam int FDIG_DEPTH    = 32;
	localparam int FIDX_W        = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAC = 2'd1;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [FIDX_W-1:0]  MAX_FRAC_RESET = 5'd6;

	localparam logic [CHAR_W-1:0] CH_ZERO      = 7'd48;
	localparam logic [CHAR_W-1:0] CH_ALPHA_OFS = 7'd55;
	localparam logic [CHAR_W-1:0] CH_MINUS     = 7'd45;
	localparam logic [CHAR_W-1:0] CH_POINT     = 7'd46;
	localparam logic [DIG_W-1:0]  DIG_NINE     = 4'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FRAC,
		ST_SIGN,
		ST_INT,
		ST_POINT,
		ST_FDIG
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_FRAC,
		OP_SIGN,
		OP_INT,
		OP_POINT,
		OP_FDIG
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic frac_done;
		logic need_sign;
		logic int_at_end;
		logic has_frac;
		logic frac_at_end;
	} status_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
		if (d <= DIG_NINE) begin
			return CH_ZERO + CHAR_W'(d);
		end
		return CH_ALPHA_OFS + CHAR_W'(d);
	endfunction

endpackage

[rtl/core/fixed_point_to_radix_text_unit.sv]
// Radix text unit top level: configuration registers, sequencer, datapath.
// Depends on fprt_pkg, fprt_ctrl, fprt_dp and the assertion macro header.
//
// A request is taken when start is high and busy is low; negative,
// int_magnitude and frac_magnitude are sampled on that edge. busy stays
// high until the last character of the number is on char_code.
// Characters leave one per cycle on char_code, marked by char_strobe;
// last_char flags the final one. The receiver cannot stall.
// Integer digits come from a divider by the radix that retires four
// quotient bits a cycle, one full pass over the dividend per digit.
// Fraction digits come from one multiply by the radix each, until the
// fraction is zero or the limit is reached; trailing zeros are dropped.
// Configuration (index 0 radix, index 1 max_frac_digits) is always
// ready; write it only while idle. Radix values outside 2..16 saturate.
// Reset sets radix 10, six fraction digits, and the sequencer idle.
`include "fixed_point_to_radix_text_unit_macros.svh"

module fixed_point_to_radix_text_unit #(
	parameter int INT_BITS  = 31,
	parameter int FRAC_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 negative,
	input  logic [INT_BITS-1:0]                  int_magnitude,
	input  logic [FRAC_BITS-1:0]                 frac_magnitude,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fprt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fprt_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 char_strobe,
	output logic [fprt_pkg::CHAR_W-1:0]          char_code,
	output logic                                 last_char
);

	logic [fprt_pkg::RADIX_W-1:0] radix_q;
	logic [fprt_pkg::FIDX_W-1:0]  max_frac_q;
	logic [fprt_pkg::RADIX_W-1:0] radix_eff;
	fprt_pkg::cmd_t               cmd;
	fprt_pkg::status_t            st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= fprt_pkg::RADIX_RESET;
			max_frac_q <= fprt_pkg::MAX_FRAC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fprt_pkg::CFG_RADIX:    radix_q    <= cfg_data;
				fprt_pkg::CFG_MAX_FRAC: max_frac_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (radix_q < fprt_pkg::RADIX_MIN) begin
			radix_eff = fprt_pkg::RADIX_MIN;
		end else if (radix_q > fprt_pkg::RADIX_MAX) begin
			radix_eff = fprt_pkg::RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	fprt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	fprt_dp #(
		.INT_BITS  (INT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.radix          (radix_eff),
		.max_frac       (max_frac_q),
		.negative       (negative),
		.int_magnitude  (int_magnitude),
		.frac_magnitude (frac_magnitude),
		.st             (st),
		.char_strobe    (char_strobe),
		.char_code      (char_code),
		.last_char      (last_char)
	);

	`FPRT_ASSERT_NOW(a_last_frees, char_strobe && last_char, !busy, "busy held after last character")
	`FPRT_ASSERT_NOW(a_radix_range, 1'b1, (radix_eff >= fprt_pkg::RADIX_MIN) && (radix_eff <= fprt_pkg::RADIX_MAX), "effective radix out of range")
	`FPRT_ASSERT_NEXT(a_take_sets_busy, start && !busy, busy, "request taken without going busy")

endmodule

[rtl/core/fprt_ctrl.sv]
// Sequencer for the radix text unit: division, fraction and emit phases.
// Depends on fprt_pkg and the assertion macro header.
`include "fixed_point_to_radix_text_unit_macros.svh"

module fprt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  fprt_pkg::status_t st,
	output fprt_pkg::cmd_t   cmd,
	output logic             busy
);

	fprt_pkg::state_t state_q;
	fprt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fprt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = fprt_pkg::OP_NONE;
		unique case (state_q)
			fprt_pkg::ST_IDLE: begin
				if (start) begin
					cmd.op  = fprt_pkg::OP_LOAD;
					state_d = fprt_pkg::ST_DIV;
				end
			end
			fprt_pkg::ST_DIV: begin
				cmd.op = fprt_pkg::OP_DIV;
				if (st.div_done) begin
					state_d = fprt_pkg::ST_FRAC;
				end
			end
			fprt_pkg::ST_FRAC: begin
				if (st.frac_done) begin
					state_d = st.need_sign ? fprt_pkg::ST_SIGN : fprt_pkg::ST_INT;
				end else begin
					cmd.op = fprt_pkg::OP_FRAC;
				end
			end
			fprt_pkg::ST_SIGN: begin
				cmd.op  = fprt_pkg::OP_SIGN;
				state_d = fprt_pkg::ST_INT;
			end
			fprt_pkg::ST_INT: begin
				cmd.op = fprt_pkg::OP_INT;
				if (st.int_at_end) begin
					state_d = st.has_frac ? fprt_pkg::ST_POINT : fprt_pkg::ST_IDLE;
				end
			end
			fprt_pkg::ST_POINT: begin
				cmd.op  = fprt_pkg::OP_POINT;
				state_d = fprt_pkg::ST_FDIG;
			end
			fprt_pkg::ST_FDIG: begin
				cmd.op = fprt_pkg::OP_FDIG;
				if (st.frac_at_end) begin
					state_d = fprt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fprt_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != fprt_pkg::ST_IDLE);

	`FPRT_ASSERT_NEXT(a_start_to_div, (state_q == fprt_pkg::ST_IDLE) && start, state_q == fprt_pkg::ST_DIV, "request not taken into division")
	`FPRT_ASSERT_NEXT(a_sign_to_int, state_q == fprt_pkg::ST_SIGN, state_q == fprt_pkg::ST_INT, "sign not followed by integer digits")
	`FPRT_ASSERT_NEXT(a_point_to_fdig, state_q == fprt_pkg::ST_POINT, state_q == fprt_pkg::ST_FDIG, "point not followed by fraction digits")
	`FPRT_ASSERT_NEXT(a_int_stays, (state_q == fprt_pkg::ST_INT) && !st.int_at_end, state_q == fprt_pkg::ST_INT, "integer digits cut short")

endmodule

[rtl/core/fprt_dp.sv]
// Datapath for the radix text unit: radix divider, fraction multiplier,
// digit stores and character register. Depends on fprt_pkg and macro header.
`include "fixed_point_to_radix_text_unit_macros.svh"

module fprt_dp #(
	parameter int INT_BITS  = 31,
	parameter int FRAC_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fprt_pkg::cmd_t                    cmd,
	input  logic [fprt_pkg::RADIX_W-1:0]      radix,
	input  logic [fprt_pkg::FIDX_W-1:0]       max_frac,
	input  logic                              negative,
	input  logic [INT_BITS-1:0]               int_magnitude,
	input  logic [FRAC_BITS-1:0]              frac_magnitude,
	output fprt_pkg::status_t                 st,
	output logic                              char_strobe,
	output logic [fprt_pkg::CHAR_W-1:0]       char_code,
	output logic                              last_char
);

	localparam int BPS     = fprt_pkg::BITS_PER_STEP;
	localparam int DW      = fprt_pkg::DIG_W;
	localparam int FW      = fprt_pkg::FIDX_W;
	localparam int STEPS   = (INT_BITS + BPS - 1) / BPS;
	localparam int IW      = STEPS * BPS;
	localparam int STEP_W  = $clog2(STEPS);
	localparam int IDX_W   = $clog2(INT_BITS);
	localparam int PW      = FRAC_BITS + fprt_pkg::RADIX_W;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

	logic [IW-1:0]        dvd_q;
	logic [DW-1:0]        rem_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [DW-1:0]        idig_q [INT_BITS];
	logic [DW-1:0]        fdig_q [fprt_pkg::FDIG_DEPTH];
	logic [fprt_pkg::CHAR_W-1:0] char_q;

	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0]  icnt_q;
	logic [IDX_W-1:0]  iptr_q;
	logic [FW-1:0]     fcnt_q;
	logic [FW-1:0]     ftrim_q;
	logic [FW-1:0]     fptr_q;
	logic              neg_q;
	logic              strobe_q;
	logic              last_q;

	logic [DW:0]       t_w;
	logic [DW-1:0]     rem_w;
	logic [BPS-1:0]    qbits_w;
	logic [IW-1:0]     dvd_next;
	logic              step_last_w;
	logic [PW-1:0]     prod_w;
	logic [DW-1:0]     fdig_new;
	logic [fprt_pkg::CHAR_W-1:0] char_w;
	logic              last_w;
	logic              emit_w;

	// four restoring division steps per cycle
	always_comb begin
		rem_w   = rem_q;
		qbits_w = '0;
		t_w     = '0;
		for (int k = 0; k < BPS; k++) begin
			t_w = {rem_w, dvd_q[IW-1-k]};
			if (t_w >= radix) begin
				qbits_w[BPS-1-k] = 1'b1;
				rem_w = DW'(t_w - radix);
			end else begin
				rem_w = t_w[DW-1:0];
			end
		end
		dvd_next = {dvd_q[IW-BPS-1:0], qbits_w};
	end

	assign step_last_w = (step_q == STEP_LAST);
	assign prod_w      = PW'(frac_q) * PW'(radix);
	assign fdig_new    = prod_w[FRAC_BITS+DW-1:FRAC_BITS];

	assign st.div_done    = step_last_w && (dvd_next == '0);
	assign st.frac_done   = (frac_q == '0) || (fcnt_q == max_frac);
	assign st.need_sign   = neg_q;
	assign st.int_at_end  = (iptr_q == '0);
	assign st.has_frac    = (ftrim_q != '0);
	assign st.frac_at_end = (fptr_q == FW'(ftrim_q - 1'b1));

	always_comb begin
		unique case (cmd.op)
			fprt_pkg::OP_SIGN:  char_w = fprt_pkg::CH_MINUS;
			fprt_pkg::OP_INT:   char_w = fprt_pkg::digit_char(idig_q[iptr_q]);
			fprt_pkg::OP_POINT: char_w = fprt_pkg::CH_POINT;
			fprt_pkg::OP_FDIG:  char_w = fprt_pkg::digit_char(fdig_q[fptr_q]);
			default:            char_w = fprt_pkg::CH_ZERO;
		endcase
	end

	assign emit_w = (cmd.op == fprt_pkg::OP_SIGN) || (cmd.op == fprt_pkg::OP_INT) ||
	                (cmd.op == fprt_pkg::OP_POINT) || (cmd.op == fprt_pkg::OP_FDIG);
	assign last_w = ((cmd.op == fprt_pkg::OP_INT) && st.int_at_end && !st.has_frac) ||
	                ((cmd.op == fprt_pkg::OP_FDIG) && st.frac_at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			icnt_q   <= '0;
			iptr_q   <= '0;
			fcnt_q   <= '0;
			ftrim_q  <= '0;
			fptr_q   <= '0;
			neg_q    <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= emit_w;
			last_q   <= last_w;
			unique case (cmd.op)
				fprt_pkg::OP_LOAD: begin
					step_q  <= '0;
					icnt_q  <= '0;
					fcnt_q  <= '0;
					ftrim_q <= '0;
					fptr_q  <= '0;
					neg_q   <= negative && ((|int_magnitude) || (|frac_magnitude));
				end
				fprt_pkg::OP_DIV: begin
					if (step_last_w) begin
						step_q <= '0;
						icnt_q <= IDX_W'(icnt_q + 1'b1);
						iptr_q <= icnt_q;
					end else begin
						step_q <= STEP_W'(step_q + 1'b1);
					end
				end
				fprt_pkg::OP_FRAC: begin
					fcnt_q <= FW'(fcnt_q + 1'b1);
					if (fdig_new != '0) begin
						ftrim_q <= FW'(fcnt_q + 1'b1);
					end
				end
				fprt_pkg::OP_INT: begin
					if (iptr_q != '0) begin
						iptr_q <= IDX_W'(iptr_q - 1'b1);
					end
				end
				fprt_pkg::OP_FDIG: begin
					fptr_q <= FW'(fptr_q + 1'b1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		char_q <= char_w;
		unique case (cmd.op)
			fprt_pkg::OP_LOAD: begin
				dvd_q  <= IW'(int_magnitude);
				rem_q  <= '0;
				frac_q <= frac_magnitude;
			end
			fprt_pkg::OP_DIV: begin
				dvd_q <= dvd_next;
				if (step_last_w) begin
					idig_q[icnt_q] <= rem_w;
					rem_q <= '0;
				end else begin
					rem_q <= rem_w;
				end
			end
			fprt_pkg::OP_FRAC: begin
				frac_q         <= prod_w[FRAC_BITS-1:0];
				fdig_q[fcnt_q] <= fdig_new;
			end
			default: begin
			end
		endcase
	end

	assign char_strobe = strobe_q;
	assign char_code   = char_q;
	assign last_char   = last_q;

	`FPRT_ASSERT_NOW(a_trim_within_count, 1'b1, ftrim_q <= fcnt_q, "trimmed fraction count beyond digits made")
	`FPRT_ASSERT_NEXT(a_load_clears, cmd.op == fprt_pkg::OP_LOAD, (fcnt_q == '0) && (ftrim_q == '0) && (step_q == '0), "request load left counters set")
	`FPRT_ASSERT_NOW(a_frac_limit, cmd.op == fprt_pkg::OP_FRAC, fcnt_q < max_frac, "fraction digit made past limit")

endmodule

[tb/fixed_point_to_radix_text_unit_test.sv]
`timescale 1ns / 100ps
// Testbench for fixed_point_to_radix_text_unit: directed numbers, then random numbers
// under several radix and fraction-length settings, checked character by character.
// Depends on fprt_pkg and the unit RTL only.
module fixed_point_to_radix_text_unit_test;

	localparam logic [fprt_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [fprt_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASES = 10;
	localparam int unsigned NUMBERS_PER_PHASE = 50;

	typedef enum logic [1:0] {ACT_NUMBER, ACT_WRITE, ACT_HOLD} act_t;

	typedef struct {
		act_t                            act;
		int unsigned                     gap;
		logic                            neg;
		logic [30:0]                     im;
		logic [31:0]                     fm;
		logic [fprt_pkg::CFG_IDX_W-1:0]  idx;
		logic [fprt_pkg::CFG_DATA_W-1:0] data;
	} job_t;

	typedef struct packed {
		logic [fprt_pkg::CHAR_W-1:0] code;
		logic                        last;
	} text_char_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            negative = 1'b0;
	logic [30:0]                     int_magnitude = '0;
	logic [31:0]                     frac_magnitude = '0;
	logic                            cfg_valid = 1'b0;
	logic [fprt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fprt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            busy;
	logic                            cfg_ready;
	logic                            char_strobe;
	logic [fprt_pkg::CHAR_W-1:0]     char_code;
	logic                            last_char;

	logic [fprt_pkg::RADIX_W-1:0]    mdl_radix = fprt_pkg::RADIX_RESET;
	logic [fprt_pkg::FIDX_W-1:0]     mdl_frac_limit = fprt_pkg::MAX_FRAC_RESET;
	text_char_t                      pending_chars[$];
	job_t                            job_q[$];
	int unsigned                     fail_count = 0;
	int unsigned                     quiet_cycles = 0;
	int unsigned                     hold_cycles = 0;

	fixed_point_to_radix_text_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.negative       (negative),
		.int_magnitude  (int_magnitude),
		.frac_magnitude (frac_magnitude),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.char_strobe    (char_strobe),
		.char_code      (char_code),
		.last_char      (last_char)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [fprt_pkg::CHAR_W-1:0] digit_code(input logic [3:0] d);
		if (d < 4'd10) begin
			return fprt_pkg::CH_ZERO + fprt_pkg::CHAR_W'(d);
		end
		return fprt_pkg::CH_ALPHA_OFS + fprt_pkg::CHAR_W'(d);
	endfunction

	function automatic void add_char(input logic [fprt_pkg::CHAR_W-1:0] code,
			input logic last);
		text_char_t ch;
		ch.code = code;
		ch.last = last;
		pending_chars = {pending_chars, ch};
	endfunction

	// Text of one number under the current register settings, queued as expected characters.
	function automatic void render_number(input logic neg, input logic [30:0] im,
			input logic [31:0] fm);
		int unsigned base;
		logic [30:0] iv;
		logic [31:0] fv;
		logic [63:0] prod;
		logic [3:0] int_digits[32];
		logic [3:0] frac_digits[32];
		int ni;
		int nf;
		int total;
		int pos;
		logic show_minus;
		if (mdl_radix < fprt_pkg::RADIX_MIN) begin
			base = fprt_pkg::RADIX_MIN;
		end else if (mdl_radix > fprt_pkg::RADIX_MAX) begin
			base = fprt_pkg::RADIX_MAX;
		end else begin
			base = mdl_radix;
		end
		ni = 0;
		iv = im;
		do begin
			int_digits[ni] = 4'(iv % base);
			iv = 31'(iv / base);
			ni++;
		end while (iv != 0);
		nf = 0;
		fv = fm;
		while (fv != 0 && nf < int'(mdl_frac_limit)) begin
			prod = 64'(fv) * 64'(base);
			frac_digits[nf] = prod[35:32];
			fv = prod[31:0];
			nf++;
		end
		while (nf > 0 && frac_digits[nf-1] == 4'd0) begin
			nf--;
		end
		show_minus = neg && (im != 0 || fm != 0);
		total = (show_minus ? 1 : 0) + ni + ((nf > 0) ? nf + 1 : 0);
		pos = 0;
		if (show_minus) begin
			pos++;
			add_char(fprt_pkg::CH_MINUS, pos == total);
		end
		for (int i = ni - 1; i >= 0; i--) begin
			pos++;
			add_char(digit_code(int_digits[i]), pos == total);
		end
		if (nf > 0) begin
			pos++;
			add_char(fprt_pkg::CH_POINT, pos == total);
			for (int i = 0; i < nf; i++) begin
				pos++;
				add_char(digit_code(frac_digits[i]), pos == total);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input int unsigned exp_v,
			input int unsigned got_v);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
		fail_count++;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 12) begin
			return 0;
		end
		if (roll < 18) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(15, 60);
	endfunction

	function automatic job_t number_job(input logic neg, input logic [30:0] im,
			input logic [31:0] fm, input int unsigned gap);
		job_t j;
		j.act = ACT_NUMBER;
		j.gap = gap;
		j.neg = neg;
		j.im = im;
		j.fm = fm;
		j.idx = fprt_pkg::CFG_RADIX;
		j.data = '0;
		return j;
	endfunction

	function automatic job_t write_job(input logic [fprt_pkg::CFG_IDX_W-1:0] idx,
			input logic [fprt_pkg::CFG_DATA_W-1:0] data);
		job_t j;
		j = number_job(1'b0, '0, '0, 0);
		j.act = ACT_WRITE;
		j.idx = idx;
		j.data = data;
		return j;
	endfunction

	function automatic job_t random_number(input int unsigned gap);
		logic [30:0] im;
		logic [31:0] fm;
		case ($urandom_range(0, 3))
			0: im = 31'($urandom_range(0, 20));
			1: im = 31'($urandom) & ((31'd1 << $urandom_range(1, 30)) - 31'd1);
			2: im = 31'($urandom);
			default: im = {31{1'b1}} >> $urandom_range(0, 3);
		endcase
		case ($urandom_range(0, 4))
			0: fm = '0;
			1: fm = $urandom & (32'hFFFF_FFFF << $urandom_range(24, 31));
			2: fm = $urandom;
			3: fm = 32'hFFFF_FFFF;
			default: fm = 32'($urandom_range(1, 255));
		endcase
		return number_job(1'($urandom), im, fm, gap);
	endfunction

	function automatic void queue_job(input job_t j);
		job_q = {job_q, j};
	endfunction

	// Request driver: numbers go out as soon as allowed, register writes and holds wait for idle.
	always @(posedge clk or negedge arst_n) begin
		job_t job;
		logic nxt_start;
		logic nxt_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			negative <= 1'b0;
			int_magnitude <= '0;
			frac_magnitude <= '0;
			cfg_index <= '0;
			cfg_data <= '0;
			quiet_cycles = 0;
			hold_cycles = 0;
		end else begin
			nxt_start = start;
			nxt_cfg = cfg_valid;
			if (start && !busy) begin
				nxt_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				nxt_cfg = 1'b0;
			end
			if (pending_chars.size() == 0 && !busy && !start && !cfg_valid) begin
				quiet_cycles++;
			end else begin
				quiet_cycles = 0;
			end
			if (!nxt_start && !nxt_cfg && job_q.size() != 0) begin
				job = job_q[0];
				if (hold_cycles < job.gap) begin
					hold_cycles++;
				end else begin
					case (job.act)
						ACT_NUMBER: begin
							negative <= job.neg;
							int_magnitude <= job.im;
							frac_magnitude <= job.fm;
							nxt_start = 1'b1;
							void'(job_q.pop_front());
							hold_cycles = 0;
						end
						ACT_WRITE: if (quiet_cycles >= SETTLE_CYCLES) begin
							cfg_index <= job.idx;
							cfg_data <= job.data;
							nxt_cfg = 1'b1;
							void'(job_q.pop_front());
							hold_cycles = 0;
						end
						default: if (quiet_cycles >= SETTLE_CYCLES) begin
							void'(job_q.pop_front());
							hold_cycles = 0;
						end
					endcase
				end
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// Monitor: tracks accepted writes and requests, checks each character as it leaves.
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			mdl_radix = fprt_pkg::RADIX_RESET;
			mdl_frac_limit = fprt_pkg::MAX_FRAC_RESET;
			pending_chars.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fprt_pkg::CFG_RADIX: mdl_radix = cfg_data;
					fprt_pkg::CFG_MAX_FRAC: mdl_frac_limit = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				render_number(negative, int_magnitude, frac_magnitude);
			end
			if (char_strobe) begin
				if (pending_chars.size() == 0) begin
					report_mismatch("unexpected character, code", 0, char_code);
				end else begin
					want = pending_chars.pop_front();
					if (char_code !== want.code) begin
						report_mismatch("char_code", want.code, char_code);
					end
					if (last_char !== want.last) begin
						report_mismatch("last_char", want.last, last_char);
					end
				end
			end
		end
	end

	initial begin
		int unsigned gap;
		logic [fprt_pkg::CFG_DATA_W-1:0] set_radix;
		logic [fprt_pkg::CFG_DATA_W-1:0] set_frac;
		// directed, reset settings: radix ten, six fraction digits
		queue_job(number_job(1'b0, '0, '0, 0));
		queue_job(number_job(1'b1, '0, '0, 0));
		queue_job(number_job(1'b1, '0, 32'h0000_0001, 0));
		queue_job(number_job(1'b0, {31{1'b1}}, 32'hFFFF_FFFF, 0));
		queue_job(number_job(1'b1, {31{1'b1}}, 32'hFFFF_FFFF, 2));
		queue_job(number_job(1'b0, 31'd5, 32'h8000_0000, 0));
		queue_job(number_job(1'b0, 31'd1, 32'h1999_999A, 0));
		queue_job(number_job(1'b0, 31'd123456789, '0, 0));
		queue_job(number_job(1'b1, 31'd3, 32'h0000_0001, 0));
		queue_job(number_job(1'b0, 31'd1, 32'h4000_0000, 0));
		// spare indexes must leave the registers alone
		queue_job(write_job(CFG_SPARE_LO, 5'd31));
		queue_job(write_job(CFG_SPARE_HI, 5'd0));
		queue_job(number_job(1'b0, 31'd987, 32'h8000_0000, 0));
		queue_job(write_job(fprt_pkg::CFG_RADIX, 5'd16));
		queue_job(write_job(fprt_pkg::CFG_MAX_FRAC, 5'd31));
		queue_job(number_job(1'b0, 31'h00AB_CDEF, 32'hFEDC_BA98, 0));
		queue_job(number_job(1'b1, 31'h7654_3210, 32'h0123_4567, 0));
		queue_job(write_job(fprt_pkg::CFG_RADIX, 5'd2));
		queue_job(number_job(1'b1, {31{1'b1}}, 32'hFFFF_FFFF, 0));
		queue_job(write_job(fprt_pkg::CFG_RADIX, 5'd10));
		queue_job(write_job(fprt_pkg::CFG_MAX_FRAC, 5'd0));
		queue_job(number_job(1'b1, '0, 32'h8000_0000, 0));
		queue_job(number_job(1'b0, 31'd42, 32'hFFFF_FFFF, 0));
		// random phases across settings, saturating radix values included
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin set_radix = 5'd2;  set_frac = 5'd31; end
				1: begin set_radix = 5'd16; set_frac = 5'd31; end
				2: begin set_radix = 5'd0;  set_frac = 5'd0;  end
				3: begin set_radix = 5'd31; set_frac = 5'd5;  end
				4: begin set_radix = 5'd1;  set_frac = 5'd12; end
				5: begin set_radix = 5'd10; set_frac = 5'd6;  end
				6: begin set_radix = 5'd7;  set_frac = 5'd31; end
				7: begin set_radix = 5'd3;  set_frac = 5'd1;  end
				8: begin set_radix = 5'd17; set_frac = 5'd20; end
				default: begin
					set_radix = 5'($urandom_range(0, 31));
					set_frac = 5'($urandom_range(0, 31));
				end
			endcase
			queue_job(write_job(fprt_pkg::CFG_RADIX, set_radix));
			queue_job(write_job(fprt_pkg::CFG_MAX_FRAC, set_frac));
			if (ph % 4 == 3) begin
				queue_job(write_job($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
					5'($urandom)));
			end
			for (int unsigned k = 0; k < NUMBERS_PER_PHASE; k++) begin
				gap = (ph % 3 == 2) ? 0 : pick_gap();
				queue_job(random_number(gap));
				if ($urandom_range(0, 24) == 0) begin
					queue_job(number_job(1'b0, '0, '0, 0));
					job_q[$].act = ACT_HOLD;
				end
			end
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (job_q.size() != 0 || start || cfg_valid || pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[fixed_point_to_radix_text_unit.f]
+incdir+rtl/core
rtl/core/fprt_pkg.sv
rtl/core/fprt_ctrl.sv
rtl/core/fprt_dp.sv
rtl/core/fixed_point_to_radix_text_unit.sv
tb/fixed_point_to_radix_text_unit_test.sv
